[rtl/sorted_table_engine_defines.svh]
// ---------------------------------------------------------------------------
// Sorted table engine assertion macros
// Shared property macros for the sorted table engine modules.
// ---------------------------------------------------------------------------
`ifndef SORTED_TABLE_ENGINE_DEFINES_SVH
`define SORTED_TABLE_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is active.
`define STE_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define STE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/ste_pkg.sv]
// ---------------------------------------------------------------------------
// Sorted table engine package
// Sizes, codes, command and status types shared by the engine modules.
// ---------------------------------------------------------------------------
package ste_pkg;

    localparam int DEPTH   = 256;
    localparam int KEY_W   = 32;
    localparam int PAY_W   = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = 8;
    localparam int POS_W   = 8;
    localparam int CNTO_W  = 9;
    localparam int ENTRY_W = KEY_W + PAY_W;

    // Request actions.
    typedef enum logic [2:0] {
        ACT_INSERT = 3'd0,
        ACT_FIND   = 3'd1,
        ACT_FOI    = 3'd2,
        ACT_READ   = 3'd3,
        ACT_CLEAR  = 3'd4
    } action_t;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_DONE  = 3'd0,
        ST_FOUND = 3'd1,
        ST_MISS  = 3'd2,
        ST_FULL  = 3'd3,
        ST_RANGE = 3'd4
    } status_t;

    // Which result the datapath builds when it loads the output register.
    typedef enum logic [2:0] {
        RES_NONE,
        RES_PUT,
        RES_HIT,
        RES_MISS,
        RES_FULL,
        RES_RANGE,
        RES_READ
    } res_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic bs_init;
        logic bs_read;
        logic bs_step;
        logic rd_pos;
        logic rd_idx;
        logic sh_init;
        logic sh_read;
        logic sh_write;
        logic put;
        logic clear;
        logic out_load;
        res_t res;
    } ste_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        action_t action;
        logic    bs_done;
        logic    sh_done;
        logic    full;
        logic    hit;
        logic    idx_ok;
        logic    out_busy;
    } ste_stat_t;

    // Key ordering, unsigned or two's complement.
    function automatic logic key_less(input logic [KEY_W-1:0] a,
                                      input logic [KEY_W-1:0] b,
                                      input logic             sgn);
        logic [KEY_W-1:0] flip;
        flip = {sgn, {(KEY_W-1){1'b0}}};
        return (a ^ flip) < (b ^ flip);
    endfunction

endpackage

[rtl/ste_ram.sv]
// ---------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ---------------------------------------------------------------------------
module ste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/ste_datapath.sv]
// ---------------------------------------------------------------------------
// Sorted table engine datapath
// Request registers, search bounds, shift pointer, table memory and result.
// ---------------------------------------------------------------------------
`include "sorted_table_engine_defines.svh"

module ste_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  ste_pkg::ste_cmd_t          cmd,
    output ste_pkg::ste_stat_t         stat,
    input  logic                       cfg_we,
    input  logic                       cfg_wdata,
    input  logic [2:0]                 in_action,
    input  logic [ste_pkg::KEY_W-1:0]  in_key,
    input  logic [ste_pkg::PAY_W-1:0]  in_payload,
    input  logic [ste_pkg::IDX_W-1:0]  in_index,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [2:0]                 out_status,
    output logic [ste_pkg::POS_W-1:0]  out_position,
    output logic [ste_pkg::KEY_W-1:0]  out_key,
    output logic [ste_pkg::PAY_W-1:0]  out_payload,
    output logic [ste_pkg::CNTO_W-1:0] out_count
);
    import ste_pkg::*;

    logic                 sgn_reg;
    action_t              act_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [PAY_W-1:0]     pay_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     lo_reg, hi_reg, ptr_reg, cnt_reg;
    logic                 ov_reg;
    logic [2:0]           st_reg, st_next;
    logic [POS_W-1:0]     pos_reg, pos_next;
    logic [KEY_W-1:0]     okey_reg, okey_next;
    logic [PAY_W-1:0]     opay_reg, opay_next;
    logic [CNTO_W-1:0]    ocnt_reg;

    logic [CNT_W:0]       sum;
    logic [CNT_W-1:0]     mid;
    logic [CNT_W-1:0]     ptr_dec;
    logic [ENTRY_W-1:0]   rdata;
    logic [KEY_W-1:0]     m_key;
    logic [PAY_W-1:0]     m_pay;
    logic                 go_right;
    logic                 ram_we, ram_re;
    logic [ADDR_W-1:0]    waddr, raddr;
    logic [ENTRY_W-1:0]   wdata;

    assign sum     = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid     = sum[CNT_W:1];
    assign ptr_dec = ptr_reg - 1'b1;
    assign m_key   = rdata[KEY_W-1:0];
    assign m_pay   = rdata[ENTRY_W-1:KEY_W];

    // Insert searches past equal keys; find stops at the first equal key.
    assign go_right = (act_reg == ACT_INSERT) ? !key_less(key_reg, m_key, sgn_reg)
                                              : key_less(m_key, key_reg, sgn_reg);

    // Memory port selection.
    assign ram_we = cmd.sh_write || cmd.put;
    assign waddr  = cmd.sh_write ? ptr_reg[ADDR_W-1:0] : lo_reg[ADDR_W-1:0];
    assign wdata  = cmd.sh_write ? rdata : {pay_reg, key_reg};
    assign ram_re = cmd.bs_read || cmd.rd_pos || cmd.rd_idx || cmd.sh_read;

    always_comb
    begin
        priority if (cmd.bs_read)
            raddr = mid[ADDR_W-1:0];
        else if (cmd.rd_pos)
            raddr = lo_reg[ADDR_W-1:0];
        else if (cmd.rd_idx)
            raddr = idx_reg[ADDR_W-1:0];
        else
            raddr = ptr_dec[ADDR_W-1:0];
    end

    ste_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (ram_re),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Status toward the controller.
    assign stat.action   = act_reg;
    assign stat.bs_done  = (lo_reg == hi_reg);
    assign stat.sh_done  = (ptr_reg == lo_reg);
    assign stat.full     = (cnt_reg == CNT_W'(DEPTH));
    assign stat.hit      = (lo_reg < cnt_reg) && (m_key == key_reg);
    assign stat.idx_ok   = (CNT_W'(idx_reg) < cnt_reg) && (int'(idx_reg) < DEPTH);
    assign stat.out_busy = ov_reg && !out_ready;

    // Control registers: configuration, entry count and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sgn_reg <= 1'b0;
            cnt_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                sgn_reg <= cfg_wdata;
            end
            if (cmd.clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.put)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (cmd.out_load)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    // Request, search and shift registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            act_reg <= action_t'(in_action);
            key_reg <= in_key;
            pay_reg <= in_payload;
            idx_reg <= in_index;
        end
        if (cmd.bs_init)
        begin
            lo_reg <= '0;
            hi_reg <= cnt_reg;
        end
        else if (cmd.bs_step)
        begin
            if (go_right)
                lo_reg <= mid + 1'b1;
            else
                hi_reg <= mid;
        end
        if (cmd.sh_init)
        begin
            ptr_reg <= cnt_reg;
        end
        else if (cmd.sh_write)
        begin
            ptr_reg <= ptr_dec;
        end
    end

    // Result fields for the selected result kind; hidden fields read as zero.
    always_comb
    begin
        st_next   = ST_DONE;
        pos_next  = '0;
        okey_next = '0;
        opay_next = '0;
        unique case (cmd.res)
            RES_PUT:
            begin
                pos_next  = lo_reg[POS_W-1:0];
                okey_next = key_reg;
                opay_next = pay_reg;
            end
            RES_HIT:
            begin
                st_next   = ST_FOUND;
                pos_next  = lo_reg[POS_W-1:0];
                okey_next = m_key;
                opay_next = m_pay;
            end
            RES_READ:
            begin
                pos_next  = idx_reg;
                okey_next = m_key;
                opay_next = m_pay;
            end
            RES_MISS:  st_next = ST_MISS;
            RES_FULL:  st_next = ST_FULL;
            RES_RANGE: st_next = ST_RANGE;
            RES_NONE:  st_next = ST_DONE;
            default:   st_next = ST_DONE;
        endcase
    end

    // Result register, including the entry count seen by this item.
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            st_reg   <= st_next;
            pos_reg  <= pos_next;
            okey_reg <= okey_next;
            opay_reg <= opay_next;
            ocnt_reg <= CNTO_W'(cnt_reg);
        end
    end

    assign out_valid    = ov_reg;
    assign out_status   = st_reg;
    assign out_position = pos_reg;
    assign out_key      = okey_reg;
    assign out_payload  = opay_reg;
    assign out_count    = ocnt_reg;

    // Checks on table bookkeeping.
    `STE_ASSERT_NOW(a_count_max, clk, rst_n, 1'b1, cnt_reg <= CNT_W'(DEPTH),
        "entry count above table depth")
    `STE_ASSERT_NOW(a_put_room, clk, rst_n, cmd.put, cnt_reg < CNT_W'(DEPTH),
        "entry written into a full table")
    `STE_ASSERT_NOW(a_shift_range, clk, rst_n, cmd.sh_write, ptr_reg > lo_reg,
        "shift moved an entry at or below the insert point")
    `STE_ASSERT_NEXT(a_out_loaded, clk, rst_n, cmd.out_load, ov_reg,
        "loaded result not presented")

endmodule

[rtl/ste_ctrl.sv]
// ---------------------------------------------------------------------------
// Sorted table engine controller
// Sequences search, shift, write and result steps for one request.
// ---------------------------------------------------------------------------
`include "sorted_table_engine_defines.svh"

module ste_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ste_pkg::ste_stat_t stat,
    output ste_pkg::ste_cmd_t  cmd
);
    import ste_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_BS_RD,
        S_BS_CMP,
        S_CHK,
        S_SH_TEST,
        S_SH_WR,
        S_PUT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    res_t   res_reg, res_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        res_next   = res_reg;
        cmd        = '0;
        cmd.res    = res_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE:
            begin
                unique case (stat.action)
                    ACT_INSERT, ACT_FIND, ACT_FOI:
                    begin
                        cmd.bs_init = 1'b1;
                        state_next  = S_BS_RD;
                    end
                    ACT_READ:
                    begin
                        cmd.rd_idx = stat.idx_ok;
                        res_next   = stat.idx_ok ? RES_READ : RES_RANGE;
                        state_next = S_DONE;
                    end
                    ACT_CLEAR:
                    begin
                        cmd.clear  = 1'b1;
                        res_next   = RES_NONE;
                        state_next = S_DONE;
                    end
                    default:
                    begin
                        res_next   = RES_NONE;
                        state_next = S_DONE;
                    end
                endcase
            end
            S_BS_RD:
            begin
                if (!stat.bs_done)
                begin
                    cmd.bs_read = 1'b1;
                    state_next  = S_BS_CMP;
                end
                else if (stat.action != ACT_INSERT)
                begin
                    cmd.rd_pos = 1'b1;
                    state_next = S_CHK;
                end
                else if (stat.full)
                begin
                    res_next   = RES_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sh_init = 1'b1;
                    state_next  = S_SH_TEST;
                end
            end
            S_BS_CMP:
            begin
                cmd.bs_step = 1'b1;
                state_next  = S_BS_RD;
            end
            S_CHK:
            begin
                priority if (stat.hit)
                begin
                    res_next   = RES_HIT;
                    state_next = S_DONE;
                end
                else if (stat.action == ACT_FIND)
                begin
                    res_next   = RES_MISS;
                    state_next = S_DONE;
                end
                else if (stat.full)
                begin
                    res_next   = RES_FULL;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.sh_init = 1'b1;
                    state_next  = S_SH_TEST;
                end
            end
            S_SH_TEST:
            begin
                if (stat.sh_done)
                begin
                    state_next = S_PUT;
                end
                else
                begin
                    cmd.sh_read = 1'b1;
                    state_next  = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                cmd.sh_write = 1'b1;
                state_next   = S_SH_TEST;
            end
            S_PUT:
            begin
                cmd.put    = 1'b1;
                res_next   = RES_PUT;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered result selection.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            res_reg   <= RES_NONE;
        end
        else
        begin
            state_reg <= state_next;
            res_reg   <= res_next;
        end
    end

    // Sequencing checks.
    `STE_ASSERT_NEXT(a_accept_decode, clk, rst_n, in_valid && in_ready,
        state_reg == S_DECODE, "accepted item not decoded")
    `STE_ASSERT_NEXT(a_write_after_read, clk, rst_n, cmd.sh_read,
        cmd.sh_write, "shift read not followed by its write")
    `STE_ASSERT_NEXT(a_put_then_done, clk, rst_n, cmd.put,
        state_reg == S_DONE, "table write not followed by its result")

endmodule

[rtl/sorted_table_engine.sv]
// ---------------------------------------------------------------------------
// Sorted table engine
// Key-ordered table of up to 256 entries with insert, find, find-or-insert, read and clear.
// ---------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tuser: action; tdata: key, payload, entry_index
//  m_axis    out        tuser: status; tdata: position, key, payload, count
//  cfg       in         compare_signed register write
//
// One item is in work at a time. Find runs a binary search through the
// single-read table memory, a read and a compare per step. Insert searches
// the same way, then moves each entry at or above the insert point up one
// place, each move a read and a write on that memory. Reset empties the
// table at once; a stalled result waits in the output register without
// losing the item.
// ---------------------------------------------------------------------------
module sorted_table_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // key[31:0], payload[63:32], entry_index[71:64]
    input  logic [2:0]  s_axis_tuser,   // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [87:0] m_axis_tdata,   // position[7:0], entry_key[39:8],
                                        // entry_payload[71:40], entry_count[80:72]
    output logic [2:0]  m_axis_tuser,   // status[2:0]
    input  logic        cfg_we,
    input  logic        cfg_wdata
);
    import ste_pkg::*;

    ste_cmd_t          cmd;
    ste_stat_t         stat;
    logic [POS_W-1:0]  position;
    logic [KEY_W-1:0]  entry_key;
    logic [PAY_W-1:0]  entry_payload;
    logic [CNTO_W-1:0] entry_count;

    ste_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ste_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_action    (s_axis_tuser),
        .in_key       (s_axis_tdata[31:0]),
        .in_payload   (s_axis_tdata[63:32]),
        .in_index     (s_axis_tdata[71:64]),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_status   (m_axis_tuser),
        .out_position (position),
        .out_key      (entry_key),
        .out_payload  (entry_payload),
        .out_count    (entry_count)
    );

    // Pack the result fields, low field first, padded to whole bytes.
    assign m_axis_tdata = {7'd0, entry_count, entry_payload, entry_key, position};

endmodule
